/* hw/rtl/oarv_pkg.sv */
// Shared types, constants and register codes for the ohmmeter autorange voter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package oarv_pkg;

    localparam int unsigned TIME_BITS_DEF = 32;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned NUM_RANGES    = 4;

    localparam logic [1:0] WIN_NORMAL  = 2'd0;
    localparam logic [1:0] WIN_SHORT   = 2'd1;
    localparam logic [1:0] WIN_OPEN    = 2'd2;
    localparam logic [1:0] WIN_INVALID = 2'd3;

    localparam logic [1:0] RANGE_200  = 2'd0;
    localparam logic [1:0] RANGE_20K  = 2'd2;
    localparam logic [1:0] RANGE_200K = 2'd3;

    localparam logic [2:0] REG_UP_R200     = 3'd0;
    localparam logic [2:0] REG_UP_R2K      = 3'd1;
    localparam logic [2:0] REG_UP_R20K     = 3'd2;
    localparam logic [2:0] REG_DOWN_R2K    = 3'd3;
    localparam logic [2:0] REG_DOWN_R20K   = 3'd4;
    localparam logic [2:0] REG_DOWN_R200K  = 3'd5;
    localparam logic [2:0] REG_VOTES       = 3'd6;
    localparam logic [2:0] REG_SETTLE      = 3'd7;

    localparam logic [31:0] RST_UP_R200    = 32'd3120;
    localparam logic [31:0] RST_UP_R2K     = 32'd31200;
    localparam logic [31:0] RST_UP_R20K    = 32'd312000;
    localparam logic [31:0] RST_DOWN_R2K   = 32'd2880;
    localparam logic [31:0] RST_DOWN_R20K  = 32'd28800;
    localparam logic [31:0] RST_DOWN_R200K = 32'd288000;
    localparam logic [3:0]  RST_VOTES      = 4'd3;
    localparam logic [15:0] RST_SETTLE     = 16'd120;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_TRACK  = 2'd1,
        MODE_SETTLE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef struct packed {
        logic [31:0] up_r200;
        logic [31:0] up_r2k;
        logic [31:0] up_r20k;
        logic [31:0] down_r2k;
        logic [31:0] down_r20k;
        logic [31:0] down_r200k;
        logic [3:0]  votes_needed;
        logic [15:0] settle_ticks;
    } t_cfg;

    typedef struct packed {
        logic        sample_valid;
        logic [1:0]  window;
        logic        calc_ok;
        logic [31:0] resistance;
        t_dir [NUM_RANGES-1:0] dir;
    } t_cls;

    typedef struct packed {
        logic        settle_flag;
        logic [1:0]  cur_range;
        logic [3:0]  up_votes;
        logic [3:0]  down_votes;
        logic        value_valid;
        logic [1:0]  window;
        logic        calc_ok;
        logic [31:0] resistance;
    } t_res;

endpackage

`default_nettype wire

/* hw/rtl/oarv_front.sv */
// Front end: classifies one measurement beat into a vote direction for each range.
// Depends on oarv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oarv_front (
    input  wire oarv_pkg::t_cfg i_cfg,
    input  wire                 i_sample_valid,
    input  wire [1:0]           i_window,
    input  wire                 i_calc_ok,
    input  wire [31:0]          i_resistance,
    output oarv_pkg::t_cls      o_cls
);
    import oarv_pkg::*;

    logic [31:0] up_lim [NUM_RANGES];
    logic [31:0] dn_lim [NUM_RANGES];

    assign up_lim[0] = i_cfg.up_r200;
    assign up_lim[1] = i_cfg.up_r2k;
    assign up_lim[2] = i_cfg.up_r20k;
    assign up_lim[3] = '0;
    assign dn_lim[0] = '0;
    assign dn_lim[1] = i_cfg.down_r2k;
    assign dn_lim[2] = i_cfg.down_r20k;
    assign dn_lim[3] = i_cfg.down_r200k;

    always_comb begin
        o_cls.sample_valid = i_sample_valid;
        o_cls.window       = i_window;
        o_cls.calc_ok      = i_calc_ok;
        o_cls.resistance   = i_calc_ok ? i_resistance : '0;
        for (int r = 0; r < NUM_RANGES; r++) begin
            if (i_window == WIN_SHORT) begin
                o_cls.dir[r] = DIR_DOWN;
            end else if (i_window == WIN_OPEN) begin
                o_cls.dir[r] = DIR_UP;
            end else if (!i_calc_ok) begin
                o_cls.dir[r] = DIR_NONE;
            end else if ((r != NUM_RANGES - 1) && (i_resistance > up_lim[r])) begin
                o_cls.dir[r] = DIR_UP;
            end else if ((dn_lim[r] != '0) && (i_resistance < dn_lim[r])) begin
                o_cls.dir[r] = DIR_DOWN;
            end else begin
                o_cls.dir[r] = DIR_NONE;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/oarv_queue.sv */
// Short queue between the classifier and the range controller.
// Depends on oarv_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module oarv_queue #(
    parameter int unsigned WIDTH = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_nonempty,
    output logic [WIDTH-1:0] o_data
);
    import oarv_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_data     = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

/* hw/rtl/oarv_back.sv */
// Range controller: vote counting, range switching, settle hold and the output register.
// Depends on oarv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oarv_back #(
    parameter int unsigned TIME_BITS = oarv_pkg::TIME_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire oarv_pkg::t_cfg  i_cfg,
    input  wire                  i_q_nonempty,
    input  wire [TIME_BITS-1:0]  i_q_time,
    input  wire oarv_pkg::t_cls  i_q_cls,
    output logic                 o_q_pop,
    input  wire                  i_out_stall,
    output logic                 o_out_valid,
    output oarv_pkg::t_res       o_res
);
    import oarv_pkg::*;

    t_mode          r_mode, n_mode;
    logic [1:0]     r_range, n_range;
    logic [3:0]     r_up, n_up;
    logic [3:0]     r_dn, n_dn;
    logic [TIME_BITS-1:0] r_deadline, n_deadline;
    logic           r_hold, n_hold;
    logic [31:0]    r_held_res, n_held_res;
    logic [1:0]     r_held_win, n_held_win;
    logic           r_held_valid, n_held_valid;
    logic           r_held_cok, n_held_cok;
    logic           r_out_valid, n_out_valid;
    t_res           r_out, n_out;

    logic [TIME_BITS-1:0] diff;
    logic           settle_wait;
    logic           do_switch;
    t_dir           dir;

    assign o_q_pop = i_q_nonempty && (!r_out_valid || !i_out_stall);
    assign diff    = i_q_time - r_deadline;
    assign dir     = i_q_cls.dir[r_range];

    always_comb begin
        n_mode       = r_mode;
        n_range      = r_range;
        n_up         = r_up;
        n_dn         = r_dn;
        n_deadline   = r_deadline;
        n_hold       = r_hold;
        n_held_res   = r_held_res;
        n_held_win   = r_held_win;
        n_held_valid = r_held_valid;
        n_held_cok   = r_held_cok;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        settle_wait  = (r_mode == MODE_SETTLE) && diff[TIME_BITS-1];
        do_switch    = 1'b0;

        if (o_q_pop) begin
            n_out_valid = 1'b1;
            if (r_mode == MODE_IDLE) begin
                n_up       = '0;
                n_dn       = '0;
                n_hold     = 1'b0;
                n_deadline = '0;
                n_mode     = MODE_TRACK;
            end

            if (settle_wait) begin
                n_out.settle_flag = 1'b1;
                n_out.cur_range   = r_range;
                n_out.up_votes    = r_up;
                n_out.down_votes  = r_dn;
                n_out.value_valid = r_hold ? r_held_valid : 1'b0;
                n_out.window      = r_hold ? r_held_win : WIN_NORMAL;
                n_out.calc_ok     = r_hold ? r_held_cok : 1'b0;
                n_out.resistance  = r_hold ? r_held_res : '0;
            end else begin
                if (r_mode == MODE_SETTLE) begin
                    n_mode = MODE_TRACK;
                    n_hold = 1'b0;
                end
                if (i_q_cls.sample_valid) begin
                    unique case (dir)
                        DIR_UP: begin
                            if (r_range == RANGE_200K) begin
                                n_up = '0;
                                n_dn = '0;
                            end else begin
                                n_up = n_up + 1'b1;
                                n_dn = '0;
                                if (n_up >= i_cfg.votes_needed) begin
                                    n_range   = r_range + 1'b1;
                                    do_switch = 1'b1;
                                end
                            end
                        end
                        DIR_DOWN: begin
                            if (r_range == RANGE_200) begin
                                n_up = '0;
                                n_dn = '0;
                            end else begin
                                n_dn = n_dn + 1'b1;
                                n_up = '0;
                                if (n_dn >= i_cfg.votes_needed) begin
                                    n_range   = r_range - 1'b1;
                                    do_switch = 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_up = '0;
                            n_dn = '0;
                        end
                    endcase
                    if (do_switch) begin
                        n_held_res   = i_q_cls.resistance;
                        n_held_win   = i_q_cls.window;
                        n_held_valid = 1'b1;
                        n_held_cok   = i_q_cls.calc_ok;
                        n_hold       = 1'b1;
                        n_up         = '0;
                        n_dn         = '0;
                        n_deadline   = i_q_time + TIME_BITS'(i_cfg.settle_ticks);
                        n_mode       = MODE_SETTLE;
                    end
                end
                n_out.settle_flag = 1'b0;
                n_out.cur_range   = n_range;
                n_out.up_votes    = n_up;
                n_out.down_votes  = n_dn;
                n_out.value_valid = i_q_cls.sample_valid;
                n_out.window      = i_q_cls.sample_valid ? i_q_cls.window : WIN_INVALID;
                n_out.calc_ok     = i_q_cls.sample_valid && i_q_cls.calc_ok;
                n_out.resistance  = i_q_cls.sample_valid ? i_q_cls.resistance : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_range      <= RANGE_20K;
            r_up         <= '0;
            r_dn         <= '0;
            r_deadline   <= '0;
            r_hold       <= 1'b0;
            r_held_res   <= '0;
            r_held_win   <= '0;
            r_held_valid <= 1'b0;
            r_held_cok   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_range      <= n_range;
            r_up         <= n_up;
            r_dn         <= n_dn;
            r_deadline   <= n_deadline;
            r_hold       <= n_hold;
            r_held_res   <= n_held_res;
            r_held_win   <= n_held_win;
            r_held_valid <= n_held_valid;
            r_held_cok   <= n_held_cok;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

/* hw/rtl/ohmmeter_autorange_voter_unit.sv */
// Top level of the ohmmeter autorange voter: configuration registers, classifier,
// queue and range controller. Depends on oarv_pkg, oarv_front, oarv_queue, oarv_back.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    time_ms, sample_valid, window,
//                                                   calc_ok, resistance
//   output    out        o_out_valid / i_out_stall  in_settle ... resistance_out
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One beat is accepted per clock while the queue is not full; its result passes the queue and then the output register.
// The two-entry queue and the output register set the latency and absorb output stalls.
// Reset is synchronous and active low; no clearing pass follows it.
// The input stalls only when the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module ohmmeter_autorange_voter_unit #(
    parameter int unsigned TIME_BITS = oarv_pkg::TIME_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire [TIME_BITS-1:0]  i_time_ms,
    input  wire                  i_sample_valid,
    input  wire [1:0]            i_window,
    input  wire                  i_calc_ok,
    input  wire [31:0]           i_resistance,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic                 o_in_settle,
    output logic [1:0]           o_range_out,
    output logic [3:0]           o_up_votes_out,
    output logic [3:0]           o_down_votes_out,
    output logic                 o_value_valid,
    output logic [1:0]           o_window_out,
    output logic                 o_calc_ok_out,
    output logic [31:0]          o_resistance_out,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [2:0]            i_cfg_index,
    input  wire [31:0]           i_cfg_data
);
    import oarv_pkg::*;

    localparam int unsigned Q_W = TIME_BITS + $bits(t_cls);

    t_cfg            r_cfg;
    t_cls            cls;
    t_cls            q_cls;
    t_res            res;
    logic [Q_W-1:0]  q_out;
    logic [TIME_BITS-1:0] q_time;
    logic            q_full, q_nonempty, q_pop, push;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_r200      <= RST_UP_R200;
            r_cfg.up_r2k       <= RST_UP_R2K;
            r_cfg.up_r20k      <= RST_UP_R20K;
            r_cfg.down_r2k     <= RST_DOWN_R2K;
            r_cfg.down_r20k    <= RST_DOWN_R20K;
            r_cfg.down_r200k   <= RST_DOWN_R200K;
            r_cfg.votes_needed <= RST_VOTES;
            r_cfg.settle_ticks <= RST_SETTLE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_UP_R200:    r_cfg.up_r200      <= i_cfg_data;
                REG_UP_R2K:     r_cfg.up_r2k       <= i_cfg_data;
                REG_UP_R20K:    r_cfg.up_r20k      <= i_cfg_data;
                REG_DOWN_R2K:   r_cfg.down_r2k     <= i_cfg_data;
                REG_DOWN_R20K:  r_cfg.down_r20k    <= i_cfg_data;
                REG_DOWN_R200K: r_cfg.down_r200k   <= i_cfg_data;
                REG_VOTES:      r_cfg.votes_needed <= i_cfg_data[3:0];
                REG_SETTLE:     r_cfg.settle_ticks <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    oarv_front u_front (
        .i_cfg          (r_cfg),
        .i_sample_valid (i_sample_valid),
        .i_window       (i_window),
        .i_calc_ok      (i_calc_ok),
        .i_resistance   (i_resistance),
        .o_cls          (cls)
    );

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    oarv_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     ({i_time_ms, cls}),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_data     (q_out)
    );

    assign q_time = q_out[Q_W-1 -: TIME_BITS];
    assign q_cls  = q_out[$bits(t_cls)-1:0];

    oarv_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_nonempty (q_nonempty),
        .i_q_time     (q_time),
        .i_q_cls      (q_cls),
        .o_q_pop      (q_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_res        (res)
    );

    assign o_in_settle      = res.settle_flag;
    assign o_range_out      = res.cur_range;
    assign o_up_votes_out   = res.up_votes;
    assign o_down_votes_out = res.down_votes;
    assign o_value_valid    = res.value_valid;
    assign o_window_out     = res.window;
    assign o_calc_ok_out    = res.calc_ok;
    assign o_resistance_out = res.resistance;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ohmmeter_autorange_voter_unit: directed, register-extreme,
// backpressure and random tick streams are scored against an in-bench range predictor.
// Depends only on oarv_pkg and the unit's RTL.

module tb_top;
    import oarv_pkg::*;

    localparam logic [1:0] RANGE_2K    = 2'd1;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         DRAIN_PAD   = 6;
    localparam int         HOLDOFF     = 300;

    typedef struct packed {
        logic [31:0] time_ms;
        logic        sample_valid;
        logic [1:0]  window;
        logic        calc_ok;
        logic [31:0] resistance;
    } t_tick;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_time_ms;
    logic        i_sample_valid;
    logic [1:0]  i_window;
    logic        i_calc_ok;
    logic [31:0] i_resistance;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_in_settle;
    logic [1:0]  o_range_out;
    logic [3:0]  o_up_votes_out;
    logic [3:0]  o_down_votes_out;
    logic        o_value_valid;
    logic [1:0]  o_window_out;
    logic        o_calc_ok_out;
    logic [31:0] o_resistance_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    t_res        pending_readings[$];
    t_cfg        meter_cfg;
    t_mode       ar_mode;
    logic [1:0]  ar_range;
    logic [3:0]  ar_up_count;
    logic [3:0]  ar_down_count;
    logic [31:0] ar_deadline;
    logic        ar_hold;
    logic [31:0] ar_held_res;
    logic [1:0]  ar_held_win;
    logic [1:0]  ar_held_flags;

    logic [31:0] now_ms;
    t_dir        run_dir;
    int          run_left;
    int          rx_holdoff;
    int          fail_count;
    int          quiet_cycles;
    bit          tx_nogap;
    bit          rx_nogap;

    ohmmeter_autorange_voter_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_time_ms       (i_time_ms),
        .i_sample_valid  (i_sample_valid),
        .i_window        (i_window),
        .i_calc_ok       (i_calc_ok),
        .i_resistance    (i_resistance),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_in_settle     (o_in_settle),
        .o_range_out     (o_range_out),
        .o_up_votes_out  (o_up_votes_out),
        .o_down_votes_out(o_down_votes_out),
        .o_value_valid   (o_value_valid),
        .o_window_out    (o_window_out),
        .o_calc_ok_out   (o_calc_ok_out),
        .o_resistance_out(o_resistance_out),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void range_limits(input logic [1:0] rng, output logic [31:0] up_lim,
                                         output logic [31:0] dn_lim, output logic has_up);
        has_up = 1'b1;
        up_lim = '1;
        dn_lim = '0;
        case (rng)
            RANGE_200: up_lim = meter_cfg.up_r200;
            RANGE_2K: begin
                up_lim = meter_cfg.up_r2k;
                dn_lim = meter_cfg.down_r2k;
            end
            RANGE_20K: begin
                up_lim = meter_cfg.up_r20k;
                dn_lim = meter_cfg.down_r20k;
            end
            default: begin
                has_up = 1'b0;
                dn_lim = meter_cfg.down_r200k;
            end
        endcase
    endfunction

    function automatic t_res meter_step(input t_tick t);
        t_res        r;
        t_dir        dir;
        logic [31:0] up_lim;
        logic [31:0] dn_lim;
        logic [31:0] lag;
        logic [31:0] shown_res;
        logic        has_up;
        logic        switched;
        r = '0;
        if (ar_mode == MODE_IDLE) begin
            ar_up_count   = '0;
            ar_down_count = '0;
            ar_hold       = 1'b0;
            ar_deadline   = '0;
            ar_mode       = MODE_TRACK;
        end
        if (ar_mode == MODE_SETTLE) begin
            lag = t.time_ms - ar_deadline;
            if (lag[31]) begin
                r.settle_flag = 1'b1;
                r.cur_range   = ar_range;
                r.up_votes    = ar_up_count;
                r.down_votes  = ar_down_count;
                if (ar_hold) begin
                    r.value_valid = ar_held_flags[0];
                    r.window      = ar_held_win;
                    r.calc_ok     = ar_held_flags[1];
                    r.resistance  = ar_held_res;
                end
                return r;
            end
            ar_mode = MODE_TRACK;
            ar_hold = 1'b0;
        end
        if (!t.sample_valid) begin
            r.window = WIN_INVALID;
        end else begin
            shown_res = t.calc_ok ? t.resistance : '0;
            range_limits(ar_range, up_lim, dn_lim, has_up);
            if (t.window == WIN_SHORT) dir = DIR_DOWN;
            else if (t.window == WIN_OPEN) dir = DIR_UP;
            else if (!t.calc_ok) dir = DIR_NONE;
            else if (has_up && shown_res > up_lim) dir = DIR_UP;
            else if (dn_lim != '0 && shown_res < dn_lim) dir = DIR_DOWN;
            else dir = DIR_NONE;
            switched = 1'b0;
            if (dir == DIR_UP && ar_range != RANGE_200K) begin
                ar_up_count   = ar_up_count + 4'd1;
                ar_down_count = '0;
                if (ar_up_count >= meter_cfg.votes_needed) begin
                    ar_range = ar_range + 2'd1;
                    switched = 1'b1;
                end
            end else if (dir == DIR_DOWN && ar_range != RANGE_200) begin
                ar_down_count = ar_down_count + 4'd1;
                ar_up_count   = '0;
                if (ar_down_count >= meter_cfg.votes_needed) begin
                    ar_range = ar_range - 2'd1;
                    switched = 1'b1;
                end
            end else begin
                ar_up_count   = '0;
                ar_down_count = '0;
            end
            if (switched) begin
                ar_held_res   = shown_res;
                ar_held_win   = t.window;
                ar_held_flags = {t.calc_ok, 1'b1};
                ar_hold       = 1'b1;
                ar_up_count   = '0;
                ar_down_count = '0;
                ar_deadline   = t.time_ms + {16'd0, meter_cfg.settle_ticks};
                ar_mode       = MODE_SETTLE;
            end
            r.value_valid = 1'b1;
            r.window      = t.window;
            r.calc_ok     = t.calc_ok;
            r.resistance  = shown_res;
        end
        r.cur_range  = ar_range;
        r.up_votes   = ar_up_count;
        r.down_votes = ar_down_count;
        return r;
    endfunction

    function automatic t_cfg make_cfg(input logic [31:0] up200, up2k, up20k, dn2k, dn20k,
                                      dn200k, input logic [3:0] votes,
                                      input logic [15:0] settle);
        t_cfg c;
        c.up_r200      = up200;
        c.up_r2k       = up2k;
        c.up_r20k      = up20k;
        c.down_r2k     = dn2k;
        c.down_r20k    = dn20k;
        c.down_r200k   = dn200k;
        c.votes_needed = votes;
        c.settle_ticks = settle;
        return c;
    endfunction

    function automatic logic [31:0] jitter_limit(input logic [31:0] base);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return $urandom;
        if (roll == 1) return '0;
        return base / 100 * $urandom_range(40, 160);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Voting runs of one direction dominate so that switches and settling are reached.
    task automatic make_tick(output t_tick t);
        logic [31:0] up_lim;
        logic [31:0] dn_lim;
        logic [31:0] hi;
        logic        has_up;
        int unsigned roll;
        range_limits(ar_range, up_lim, dn_lim, has_up);
        if ($urandom_range(0, 29) == 0) now_ms = $urandom;
        else now_ms = now_ms + $urandom_range(0, int'(meter_cfg.settle_ticks) / 3 + 3);
        t.time_ms      = now_ms;
        t.sample_valid = ($urandom_range(0, 19) != 0);
        t.calc_ok      = ($urandom_range(0, 15) != 0);
        t.window       = ($urandom_range(0, 7) == 0) ? WIN_INVALID : WIN_NORMAL;
        t.resistance   = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            t.window       = 2'($urandom_range(0, 3));
            t.sample_valid = ($urandom_range(0, 1) != 0);
            t.calc_ok      = ($urandom_range(0, 1) != 0);
        end else begin
            if (run_left == 0) begin
                run_dir  = t_dir'($urandom_range(0, 2));
                run_left = $urandom_range(1, int'(meter_cfg.votes_needed) + 4);
            end
            run_left--;
            case (run_dir)
                DIR_UP: begin
                    if (roll < 25 || !has_up || up_lim == '1) t.window = WIN_OPEN;
                    else if (roll < 32) t.resistance = up_lim + 32'd1;
                    else t.resistance = $urandom_range(up_lim + 32'd1, 32'hFFFF_FFFF);
                end
                DIR_DOWN: begin
                    if (roll < 25 || dn_lim == '0) t.window = WIN_SHORT;
                    else if (roll < 32) t.resistance = dn_lim - 32'd1;
                    else t.resistance = $urandom_range(0, dn_lim - 32'd1);
                end
                default: begin
                    hi = has_up ? up_lim : '1;
                    if (roll < 14) t.resistance = hi;
                    else if (roll < 22) t.resistance = dn_lim;
                    else if (dn_lim <= hi) t.resistance = $urandom_range(dn_lim, hi);
                end
            endcase
        end
    endtask

    // Offers one beat and returns at the edge that accepts it; valid stays high for a
    // following beat without a gap.
    task automatic send_tick(input t_tick t);
        int gap;
        gap = tx_nogap ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_time_ms      <= t.time_ms;
        i_sample_valid <= t.sample_valid;
        i_window       <= t.window;
        i_calc_ok      <= t.calc_ok;
        i_resistance   <= t.resistance;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_readings.push_back(meter_step(t));
    endtask

    task automatic send_fields(input logic [31:0] tm, input logic sv, input logic [1:0] win,
                               input logic cok, input logic [31:0] res);
        t_tick t;
        t.time_ms      = tm;
        t.sample_valid = sv;
        t.window       = win;
        t.calc_ok      = cok;
        t.resistance   = res;
        send_tick(t);
    endtask

    task automatic random_ticks(input int n);
        t_tick t;
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) begin
                tx_nogap = ($urandom_range(0, 3) == 0);
                rx_nogap = ($urandom_range(0, 3) == 0);
            end
            make_tick(t);
            send_tick(t);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_config(input t_cfg c);
        logic [31:0] rnd;
        drain_results();
        rnd = $urandom;
        write_reg(REG_UP_R200, c.up_r200);
        write_reg(REG_UP_R2K, c.up_r2k);
        write_reg(REG_UP_R20K, c.up_r20k);
        write_reg(REG_DOWN_R2K, c.down_r2k);
        write_reg(REG_DOWN_R20K, c.down_r20k);
        write_reg(REG_DOWN_R200K, c.down_r200k);
        write_reg(REG_VOTES, {rnd[31:4], c.votes_needed});
        write_reg(REG_SETTLE, {rnd[31:16], c.settle_ticks});
        i_cfg_valid <= 1'b0;
        meter_cfg = c;
    endtask

    task automatic test_defaults_directed();
        tx_nogap = 1'b0;
        rx_nogap = 1'b0;
        send_fields(32'd0, 1'b1, WIN_NORMAL, 1'b1, 32'd100000);
        send_fields(32'd10, 1'b1, WIN_NORMAL, 1'b1, 32'hFFFF_FFFF);
        send_fields(32'd20, 1'b0, WIN_NORMAL, 1'b1, 32'd5);
        send_fields(32'd30, 1'b1, WIN_INVALID, 1'b1, 32'hFFFF_FFFF);
        send_fields(32'd40, 1'b1, WIN_NORMAL, 1'b1, 32'hFFFF_FFFF);
        send_fields(32'd100, 1'b1, WIN_SHORT, 1'b1, 32'd0);
        send_fields(32'd159, 1'b1, WIN_SHORT, 1'b1, 32'd0);
        send_fields(32'd160, 1'b1, WIN_OPEN, 1'b1, 32'd0);
        send_fields(32'd170, 1'b1, WIN_NORMAL, 1'b1, 32'hFFFF_FFFF);
        send_fields(32'd180, 1'b1, WIN_NORMAL, 1'b0, 32'd5);
        send_fields(32'd190, 1'b1, WIN_SHORT, 1'b0, 32'd7);
        send_fields(32'd200, 1'b1, WIN_NORMAL, 1'b1, 32'd287999);
        send_fields(32'd210, 1'b1, WIN_NORMAL, 1'b1, 32'd0);
        send_fields(32'd400, 1'b1, WIN_NORMAL, 1'b1, 32'd312000);
        send_fields(32'd420, 1'b1, WIN_SHORT, 1'b1, 32'd1);
        send_fields(32'd430, 1'b1, WIN_SHORT, 1'b1, 32'd2);
        send_fields(32'd440, 1'b1, WIN_SHORT, 1'b1, 32'd3);
        send_fields(32'd560, 1'b1, WIN_NORMAL, 1'b1, 32'd0);
        send_fields(32'd570, 1'b1, WIN_NORMAL, 1'b1, 32'd0);
        send_fields(32'd580, 1'b1, WIN_NORMAL, 1'b1, 32'd0);
        send_fields(32'd700, 1'b1, WIN_SHORT, 1'b1, 32'd0);
        send_fields(32'hFFFF_FFF0, 1'b1, WIN_OPEN, 1'b1, 32'd0);
        send_fields(32'hFFFF_FFF8, 1'b1, WIN_OPEN, 1'b0, 32'hFFFF_FFFF);
        send_fields(32'hFFFF_FFFC, 1'b1, WIN_OPEN, 1'b1, 32'hAAAA_5555);
        send_fields(32'h0000_0010, 1'b1, WIN_NORMAL, 1'b1, 32'h5555_AAAA);
        send_fields(32'h0000_0074, 1'b1, WIN_NORMAL, 1'b1, 32'd3121);
        now_ms = 32'h0000_0074;
    endtask

    task automatic test_register_extremes();
        apply_config(make_cfg('0, '0, '0, '1, '1, '1, 4'd1, 16'd0));
        random_ticks(70);
        apply_config(make_cfg('1, '1, '1, '0, '0, '0, 4'd15, 16'hFFFF));
        random_ticks(70);
        apply_config(make_cfg(RST_UP_R200, RST_UP_R2K, RST_UP_R20K, RST_DOWN_R2K,
                              RST_DOWN_R20K, RST_DOWN_R200K, 4'd0, 16'd1));
        random_ticks(70);
        apply_config(make_cfg(32'd1, 32'hFFFF_FFFE, $urandom, 32'd1, 32'hFFFF_FFFF,
                              $urandom, 4'd15, 16'd0));
        random_ticks(70);
    endtask

    task automatic test_input_backpressure();
        t_tick t;
        for (int k = 0; k < 2; k++) begin
            tx_nogap   = 1'b1;
            rx_holdoff = HOLDOFF;
            for (int i = 0; i < 40; i++) begin
                make_tick(t);
                send_tick(t);
            end
        end
        tx_nogap = 1'b0;
    endtask

    task automatic test_random_regression();
        logic [15:0] settle;
        for (int p = 0; p < 8; p++) begin
            settle = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 300));
            apply_config(make_cfg(jitter_limit(RST_UP_R200), jitter_limit(RST_UP_R2K),
                                  jitter_limit(RST_UP_R20K), jitter_limit(RST_DOWN_R2K),
                                  jitter_limit(RST_DOWN_R20K), jitter_limit(RST_DOWN_R200K),
                                  4'($urandom_range(0, 15)), settle));
            random_ticks(125);
        end
    endtask

    initial begin : result_sink
        int n;
        i_out_stall = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_holdoff > 0) begin
                n = rx_holdoff;
                rx_holdoff = 0;
            end else begin
                n = rx_nogap ? 0 : $urandom_range(0, 13);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : score_results
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_readings.size() == 0) begin
                $error("result beat with no reading pending");
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                check_field("o_in_settle", want.settle_flag, o_in_settle);
                check_field("range_out", want.cur_range, o_range_out);
                check_field("up_votes_out", want.up_votes, o_up_votes_out);
                check_field("down_votes_out", want.down_votes, o_down_votes_out);
                check_field("value_valid", want.value_valid, o_value_valid);
                check_field("window_out", want.window, o_window_out);
                check_field("calc_ok_out", want.calc_ok, o_calc_ok_out);
                check_field("resistance_out", want.resistance, o_resistance_out);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_time_ms      = '0;
        i_sample_valid = 1'b0;
        i_window       = WIN_NORMAL;
        i_calc_ok      = 1'b0;
        i_resistance   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_UP_R200;
        i_cfg_data     = '0;
        tx_nogap       = 1'b0;
        rx_nogap       = 1'b0;
        rx_holdoff     = 0;
        fail_count     = 0;
        quiet_cycles   = 0;
        now_ms         = '0;
        run_dir        = DIR_NONE;
        run_left       = 0;
        meter_cfg      = make_cfg(RST_UP_R200, RST_UP_R2K, RST_UP_R20K, RST_DOWN_R2K,
                                  RST_DOWN_R20K, RST_DOWN_R200K, RST_VOTES, RST_SETTLE);
        ar_mode        = MODE_IDLE;
        ar_range       = RANGE_20K;
        ar_up_count    = '0;
        ar_down_count  = '0;
        ar_deadline    = '0;
        ar_hold        = 1'b0;
        ar_held_res    = '0;
        ar_held_win    = WIN_NORMAL;
        ar_held_flags  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults_directed();
        test_register_extremes();
        test_input_backpressure();
        test_random_regression();
        drain_results();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* ohmmeter_autorange_voter_unit.f */
hw/rtl/oarv_pkg.sv
hw/rtl/oarv_front.sv
hw/rtl/oarv_queue.sv
hw/rtl/oarv_back.sv
hw/rtl/ohmmeter_autorange_voter_unit.sv
tb/tb_top.sv
